[rtl/reversible_clcg4_generator_bank_top_assert.svh]
// Assertion macros for the generator bank top level
`ifndef REVERSIBLE_CLCG4_GENERATOR_BANK_TOP_ASSERT_SVH
`define REVERSIBLE_CLCG4_GENERATOR_BANK_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RCG_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rcg same-cycle check failed");

// next-cycle implication, checked out of reset
`define RCG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rcg next-cycle check failed");

`endif

[rtl/rcg_pkg.sv]
// Shared types, constants and elaboration-time helpers of the generator bank
package rcg_pkg;

	localparam int NUM_GENERATORS = 256;
	localparam int GEN_AW = (NUM_GENERATORS > 1) ? $clog2(NUM_GENERATORS) : 1;
	localparam int GEN_LAST = NUM_GENERATORS - 1;
	localparam int NLANE = 4;
	localparam int SW = 31;
	localparam int QDEPTH = 2;
	localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int APB_AW = 5;

	typedef logic [SW-1:0] seed_t;
	typedef logic [NLANE-1:0][SW-1:0] seed_vec_t;

	// component moduli, multipliers and fold constants (2^31 - modulus)
	localparam seed_vec_t MOD = {31'd2147483323, 31'd2147483423, 31'd2147483543,
		31'd2147483647};
	localparam seed_vec_t MULT = {31'd49689, 31'd138556, 31'd207707, 31'd45991};
	localparam logic [NLANE-1:0][8:0] FOLD = {9'd325, 9'd225, 9'd105, 9'd1};

	// Q0.64 reciprocals of the moduli
	localparam logic [NLANE-1:0][63:0] RECIP = {
		64'hFFFF_FFFF_FFFF_FFFF / 64'd2147483323,
		64'hFFFF_FFFF_FFFF_FFFF / 64'd2147483423,
		64'hFFFF_FFFF_FFFF_FFFF / 64'd2147483543,
		64'hFFFF_FFFF_FFFF_FFFF / 64'd2147483647};

	// command kinds
	localparam logic [2:0] KIND_DRAW = 3'd0;
	localparam logic [2:0] KIND_REV  = 3'd1;
	localparam logic [2:0] KIND_INIT = 3'd2;
	localparam logic [2:0] KIND_SUB  = 3'd3;
	localparam logic [2:0] KIND_LAST = 3'd4;
	localparam logic [2:0] KIND_SEED = 3'd5;

	// register indexes
	localparam logic [2:0] REG_SEED0   = 3'd0;
	localparam logic [2:0] REG_SEED1   = 3'd1;
	localparam logic [2:0] REG_SEED2   = 3'd2;
	localparam logic [2:0] REG_SEED3   = 3'd3;
	localparam logic [2:0] REG_GEN_LOG = 3'd4;
	localparam logic [2:0] REG_SUB_LOG = 3'd5;
	localparam logic [2:0] REG_HIGHEST = 3'd6;

	typedef struct packed {
		seed_vec_t   seed;
		logic [6:0]  gen_log;
		logic [6:0]  sub_log;
		logic [7:0]  highest;
	} cfg_t;

	typedef struct packed {
		logic [2:0]        kind;
		logic [GEN_AW-1:0] gen;
		logic              err;
	} cmd_t;

	// exact modular product by folding the high part twice
	function automatic seed_t cmul(input seed_t x, input seed_t y, input int j);
		logic [61:0] p;
		logic [39:0] t;
		logic [31:0] u;
		p = 62'(x) * 62'(y);
		t = 40'(p[61:31]) * 40'(FOLD[j]) + 40'(p[30:0]);
		u = 32'(t[39:31]) * 32'(FOLD[j]) + 32'(t[30:0]);
		if (u >= 32'(MOD[j])) u = u - 32'(MOD[j]);
		return u[SW-1:0];
	endfunction

	// a^(m-2) mod m, the inverse multiplier, evaluated at elaboration
	function automatic seed_t inv_of(input int j);
		seed_t r;
		seed_t sq;
		seed_t e;
		r = 31'd1;
		sq = MULT[j];
		e = MOD[j] - 31'd2;
		for (int i = 0; i < SW; i++) begin
			if (e[i]) r = cmul(r, sq, j);
			sq = cmul(sq, sq, j);
		end
		return r;
	endfunction

	localparam seed_vec_t INV = {inv_of(3), inv_of(2), inv_of(1), inv_of(0)};

endpackage

[rtl/rcg_ram.sv]
// Generic single-write, single-read RAM with registered read data
module rcg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/rcg_regs.sv]
// APB configuration registers
module rcg_regs import rcg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t cfg_q;
	logic wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.seed    <= {31'd44444444, 31'd33333333, 31'd22222222, 31'd11111111};
			cfg_q.gen_log <= 7'd31;
			cfg_q.sub_log <= 7'd41;
			cfg_q.highest <= 8'd255;
		end else if (wr) begin
			case (paddr[4:2])
				REG_SEED0:   cfg_q.seed[0] <= pwdata[SW-1:0];
				REG_SEED1:   cfg_q.seed[1] <= pwdata[SW-1:0];
				REG_SEED2:   cfg_q.seed[2] <= pwdata[SW-1:0];
				REG_SEED3:   cfg_q.seed[3] <= pwdata[SW-1:0];
				REG_GEN_LOG: cfg_q.gen_log <= pwdata[6:0];
				REG_SUB_LOG: cfg_q.sub_log <= pwdata[6:0];
				REG_HIGHEST: cfg_q.highest <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (paddr[4:2])
			REG_SEED0:   prdata = 32'(cfg_q.seed[0]);
			REG_SEED1:   prdata = 32'(cfg_q.seed[1]);
			REG_SEED2:   prdata = 32'(cfg_q.seed[2]);
			REG_SEED3:   prdata = 32'(cfg_q.seed[3]);
			REG_GEN_LOG: prdata = 32'(cfg_q.gen_log);
			REG_SUB_LOG: prdata = 32'(cfg_q.sub_log);
			REG_HIGHEST: prdata = 32'(cfg_q.highest);
			default:     prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

[rtl/rcg_front.sv]
// Front end: takes command words and classifies them
module rcg_front import rcg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] generator
	input  logic [2:0] s_tuser,   // [2:0] kind
	input  logic [7:0] highest,
	output logic       cmd_valid,
	output cmd_t       cmd,
	input  logic       cmd_ready
);

	logic v_q;
	cmd_t cmd_q;
	logic acc;
	logic out_of_range;

	assign s_tready = !v_q || cmd_ready;
	assign acc = s_tvalid && s_tready;

	// range check applies to per-generator kinds only
	assign out_of_range = (s_tuser <= KIND_LAST) &&
		((s_tdata > highest) || (32'(s_tdata) >= 32'(NUM_GENERATORS)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (acc) begin
			v_q <= 1'b1;
		end else if (cmd_ready) begin
			v_q <= 1'b0;
		end
	end

	// classified command
	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_q.kind <= s_tuser;
			cmd_q.gen  <= GEN_AW'(s_tdata);
			cmd_q.err  <= out_of_range;
		end
	end

	assign cmd_valid = v_q;
	assign cmd = cmd_q;

endmodule

[rtl/rcg_queue.sv]
// Short command queue between front and back
module rcg_queue import rcg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_data,
	output logic pop_valid,
	input  logic pop,
	output cmd_t pop_data
);

	cmd_t ent_q [QDEPTH];
	logic [QAW-1:0] wp_q;
	logic [QAW-1:0] rp_q;
	logic [QAW:0]   cnt_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (cnt_q != (QAW+1)'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign do_push = push_valid && push_ready;
	assign do_pop  = pop && pop_valid;
	assign pop_data = ent_q[rp_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= wp_q + 1'b1;
			if (do_pop) rp_q <= rp_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// entries
	always_ff @(posedge clk) begin
		if (do_push) ent_q[wp_q] <= push_data;
	end

endmodule

[rtl/rcg_mulmod.sv]
// Four-lane modular multiplier, three stages: product, first fold, second fold
module rcg_mulmod import rcg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  seed_vec_t a,
	input  seed_vec_t b,
	output logic      out_valid,
	output seed_vec_t r
);

	logic v_s1, v_s2, v_s3;
	logic [NLANE-1:0][61:0] p_s1;
	logic [NLANE-1:0][39:0] t_s2;
	seed_vec_t r_s3;
	logic [NLANE-1:0][31:0] u;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// second fold and final correction
	always_comb begin
		for (int j = 0; j < NLANE; j++) begin
			u[j] = 32'(t_s2[j][39:31]) * 32'(FOLD[j]) + 32'(t_s2[j][30:0]);
			if (u[j] >= 32'(MOD[j])) u[j] = u[j] - 32'(MOD[j]);
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < NLANE; j++) begin
			p_s1[j] <= 62'(a[j]) * 62'(b[j]);
			t_s2[j] <= 40'(p_s1[j][61:31]) * 40'(FOLD[j]) + 40'(p_s1[j][30:0]);
			r_s3[j] <= u[j][SW-1:0];
		end
	end

	assign out_valid = v_s3;
	assign r = r_s3;

endmodule

[rtl/rcg_frac.sv]
// Combined uniform fraction from four seeds, four stages
module rcg_frac import rcg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  seed_vec_t   s,
	output logic        out_valid,
	output logic [31:0] value
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic [NLANE-1:0][62:0] plo_s1;
	logic [NLANE-1:0][31:0] phi_s1;
	logic [NLANE-1:0][62:0] phi_full;
	logic [NLANE-1:0][63:0] term_s2;
	logic [63:0] d0_s3, d1_s3, sum;
	logic [31:0] value_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// high half of each product only matters mod 2^32
	always_comb begin
		for (int j = 0; j < NLANE; j++) begin
			phi_full[j] = 63'(s[j]) * 63'(RECIP[j][63:32]);
		end
		sum = d0_s3 + d1_s3;
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < NLANE; j++) begin
			plo_s1[j] <= 63'(s[j]) * 63'(RECIP[j][31:0]);
			phi_s1[j] <= phi_full[j][31:0];
			term_s2[j] <= {phi_s1[j], 32'd0} + {1'b0, plo_s1[j]};
		end
		d0_s3 <= term_s2[0] - term_s2[1];
		d1_s3 <= term_s2[2] - term_s2[3];
		value_s4 <= sum[63:32];
	end

	assign out_valid = v_s4;
	assign value = value_s4;

endmodule

[rtl/rcg_back.sv]
// Back end: command sequencer, seed stores and arithmetic units
module rcg_back import rcg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        q_valid,
	input  cmd_t        q_cmd,
	output logic        q_pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	output logic        m_tuser,
	output logic        idle
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_VAL  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;
	localparam logic [2:0] ST_SQ   = 3'd5;
	localparam logic [2:0] ST_FILL = 3'd6;

	logic [2:0] state_q;
	cmd_t cmd_q;
	seed_vec_t aw_q, sub_q, gmul_q, prev_q;
	logic [6:0] cnt_q;
	logic phase_q, pend_q;
	logic [GEN_AW-1:0] fill_q;
	logic [31:0] val_q;
	logic stat_q;
	logic out_v_q;
	logic [31:0] out_data_q;
	logic out_user_q;

	logic [GEN_AW-1:0] top_gen;
	logic [6:0] target;
	logic sq_done;
	logic mi_valid, mo_valid;
	seed_vec_t mi_a, mi_b, mo_r;
	logic we_init, we_last, we_cur;
	logic [GEN_AW-1:0] waddr;
	seed_vec_t wdata;
	seed_vec_t rd_init, rd_last, rd_cur;
	logic fi_valid, fo_valid;
	logic [31:0] fo_value;
	logic out_load;

	assign top_gen = (32'(cfg.highest) > 32'(GEN_LAST)) ? GEN_AW'(GEN_LAST)
		: GEN_AW'(cfg.highest);
	assign target = phase_q ? cfg.gen_log : cfg.sub_log;
	assign sq_done = (cnt_q == target);
	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign out_load = (state_q == ST_DONE) && (!out_v_q || m_tready);
	assign idle = (state_q == ST_IDLE);

	// operand select, store writes and fraction start
	always_comb begin
		mi_valid = 1'b0;
		mi_a = aw_q;
		mi_b = aw_q;
		we_init = 1'b0;
		we_last = 1'b0;
		we_cur = 1'b0;
		waddr = cmd_q.gen;
		wdata = mo_r;
		fi_valid = 1'b0;
		case (state_q)
			ST_RD: begin
				case (cmd_q.kind)
					KIND_DRAW: begin
						mi_valid = 1'b1;
						mi_a = MULT;
						mi_b = rd_cur;
					end
					KIND_REV: begin
						mi_valid = 1'b1;
						mi_a = INV;
						mi_b = rd_cur;
					end
					KIND_SUB: begin
						mi_valid = 1'b1;
						mi_a = sub_q;
						mi_b = rd_last;
					end
					KIND_INIT: begin
						we_last = 1'b1;
						we_cur = 1'b1;
						wdata = rd_init;
					end
					KIND_LAST: begin
						we_cur = 1'b1;
						wdata = rd_last;
					end
					default: ;
				endcase
			end
			ST_MUL: begin
				if (mo_valid) begin
					we_cur = 1'b1;
					we_last = (cmd_q.kind == KIND_SUB);
					fi_valid = (cmd_q.kind == KIND_DRAW);
				end
			end
			ST_SQ: begin
				if (!pend_q) begin
					if (!sq_done) begin
						mi_valid = 1'b1;
					end else if (phase_q) begin
						// generator zero takes the seed words as given
						we_init = 1'b1;
						we_last = 1'b1;
						we_cur = 1'b1;
						waddr = '0;
						wdata = cfg.seed;
					end
				end
			end
			ST_FILL: begin
				mi_a = gmul_q;
				mi_b = prev_q;
				waddr = GEN_AW'(fill_q + 1'b1);
				if (pend_q) begin
					we_init = mo_valid;
					we_last = mo_valid;
					we_cur = mo_valid;
				end else begin
					mi_valid = (fill_q != top_gen);
				end
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q <= 1'b0;
			phase_q <= 1'b0;
			cnt_q <= '0;
			fill_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						if (q_cmd.err || q_cmd.kind > KIND_SEED) begin
							state_q <= ST_DONE;
						end else if (q_cmd.kind == KIND_SEED) begin
							cnt_q <= '0;
							phase_q <= 1'b0;
							pend_q <= 1'b0;
							state_q <= ST_SQ;
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					if (cmd_q.kind == KIND_INIT || cmd_q.kind == KIND_LAST) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mo_valid) state_q <= (cmd_q.kind == KIND_DRAW) ? ST_VAL : ST_DONE;
				end
				ST_VAL: begin
					if (fo_valid) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) state_q <= ST_IDLE;
				end
				ST_SQ: begin
					if (pend_q) begin
						if (mo_valid) begin
							cnt_q <= cnt_q + 1'b1;
							pend_q <= 1'b0;
						end
					end else if (!sq_done) begin
						pend_q <= 1'b1;
					end else if (!phase_q) begin
						phase_q <= 1'b1;
						cnt_q <= '0;
					end else begin
						fill_q <= '0;
						state_q <= ST_FILL;
					end
				end
				ST_FILL: begin
					if (pend_q) begin
						if (mo_valid) begin
							fill_q <= GEN_AW'(fill_q + 1'b1);
							pend_q <= 1'b0;
						end
					end else if (fill_q == top_gen) begin
						state_q <= ST_DONE;
					end else begin
						pend_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
			val_q <= '0;
			stat_q <= q_cmd.err && (q_cmd.kind <= KIND_LAST);
			aw_q <= MULT;
		end
		if (state_q == ST_SQ) begin
			if (pend_q && mo_valid) aw_q <= mo_r;
			if (!pend_q && sq_done) begin
				if (!phase_q) sub_q <= aw_q;
				else begin
					gmul_q <= aw_q;
					prev_q <= cfg.seed;
				end
			end
		end
		if (state_q == ST_FILL && pend_q && mo_valid) prev_q <= mo_r;
		if (state_q == ST_VAL && fo_valid) val_q <= fo_value;
		if (out_load) begin
			out_data_q <= val_q;
			out_user_q <= stat_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = out_data_q;
	assign m_tuser = out_user_q;

	rcg_mulmod u_mulmod (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mi_valid),
		.a         (mi_a),
		.b         (mi_b),
		.out_valid (mo_valid),
		.r         (mo_r)
	);

	rcg_frac u_frac (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fi_valid),
		.s         (mo_r),
		.out_valid (fo_valid),
		.value     (fo_value)
	);

	rcg_ram #(.WIDTH(NLANE*SW), .DEPTH(NUM_GENERATORS)) u_init_ram (
		.clk   (clk),
		.we    (we_init),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (q_cmd.gen),
		.rdata (rd_init)
	);

	rcg_ram #(.WIDTH(NLANE*SW), .DEPTH(NUM_GENERATORS)) u_last_ram (
		.clk   (clk),
		.we    (we_last),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (q_cmd.gen),
		.rdata (rd_last)
	);

	rcg_ram #(.WIDTH(NLANE*SW), .DEPTH(NUM_GENERATORS)) u_cur_ram (
		.clk   (clk),
		.we    (we_cur),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (q_cmd.gen),
		.rdata (rd_cur)
	);

endmodule

[rtl/reversible_clcg4_generator_bank_top.sv]
// Bank of 256 four-component combined LCGs with reverse stepping and substreams.
// Commands enter on the slave stream (kind in tuser, generator in tdata), are
// range-checked, and wait in a two-word queue for the sequencer, so the input
// keeps taking words while a result waits on the master stream, until the queue
// and the front register fill. Every multiply goes through one shared
// three-stage, four-lane modular multiplier; a draw then passes the fraction
// unit. Reverse and next substream read a seed and multiply, initial or last
// seed copy a store, out-of-range or unused kinds go straight to the result.
// Seed-all squares the multiplier, then fills the bank up to the highest
// generator. Seed stores are valid only after the first seed-all command.
module reversible_clcg4_generator_bank_top import rcg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [7:0] generator
	input  logic [2:0]        s_tuser,   // [2:0] kind
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [31:0]       m_tdata,   // [31:0] uniform_value
	output logic              m_tuser,   // [0] status
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	`include "reversible_clcg4_generator_bank_top_assert.svh"

	cfg_t cfg;
	logic f_valid, f_ready;
	cmd_t f_cmd;
	logic q_valid, q_pop;
	cmd_t q_cmd;
	logic back_idle;

	rcg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rcg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.highest   (cfg.highest),
		.cmd_valid (f_valid),
		.cmd       (f_cmd),
		.cmd_ready (f_ready)
	);

	rcg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_cmd),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_data   (q_cmd)
	);

	rcg_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.idle     (back_idle)
	);

	// an error word never carries a fraction
	`RCG_ASSERT_NOW(a_err_value_zero, m_tvalid && m_tuser, m_tdata == 32'd0)
	// an idle sequencer picks up a queued command at once
	`RCG_ASSERT_NEXT(a_back_takes_cmd, q_valid && back_idle, !back_idle)

endmodule

[dv/reversible_clcg4_generator_bank_checker.sv]
// Checker for the generator bank: follows APB writes and stream words, predicts and compares
module reversible_clcg4_generator_bank_checker import rcg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] generator
	input  logic [2:0]  s_tuser,   // [2:0] kind
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [31:0] uniform_value
	input  logic        m_tuser,   // [0] status
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fails,
	output int          pending
);

	localparam logic [63:0] MODULI [4] = '{64'd2147483647, 64'd2147483543,
		64'd2147483423, 64'd2147483323};
	localparam logic [63:0] MULTS [4] = '{64'd45991, 64'd207707, 64'd138556, 64'd49689};

	typedef struct {
		logic [31:0] value;
		logic        status;
	} draw_result_t;

	draw_result_t result_q[$];

	// predictor copy of configuration and stores
	logic [30:0] seed_word [4];
	logic [6:0]  gen_log, sub_log;
	logic [7:0]  highest;
	logic [30:0] init_seed [4][256];
	logic [30:0] last_seed [4][256];
	logic [30:0] cur_seed  [4][256];
	logic [30:0] sub_mult [4];
	logic [30:0] gen_mult [4];
	logic [30:0] inv_mult [4];
	logic [63:0] recip [4];

	function automatic logic [30:0] mod_mul(input logic [30:0] x, input logic [30:0] y,
		input int j);
		logic [63:0] p;
		p = {33'd0, x} * {33'd0, y};
		return 31'(p % MODULI[j]);
	endfunction

	function automatic logic [30:0] mod_pow(input logic [63:0] b, input logic [63:0] e,
		input int j);
		logic [30:0] r;
		logic [30:0] sq;
		logic [63:0] k;
		r = 31'd1;
		sq = 31'(b % MODULI[j]);
		k = e;
		while (k != 0) begin
			if (k[0]) r = mod_mul(r, sq, j);
			sq = mod_mul(sq, sq, j);
			k = k >> 1;
		end
		return r;
	endfunction

	function automatic void seed_bank();
		logic [30:0] aw;
		for (int j = 0; j < 4; j++) begin
			aw = MULTS[j][30:0];
			for (int i = 0; i < sub_log; i++) aw = mod_mul(aw, aw, j);
			sub_mult[j] = aw;
			for (int i = 0; i < gen_log; i++) aw = mod_mul(aw, aw, j);
			gen_mult[j] = aw;
			init_seed[j][0] = seed_word[j];
			for (int g = 1; g <= highest; g++)
				init_seed[j][g] = mod_mul(aw, init_seed[j][g-1], j);
			for (int g = 0; g <= highest; g++) begin
				last_seed[j][g] = init_seed[j][g];
				cur_seed[j][g] = init_seed[j][g];
			end
		end
	endfunction

	// work out the result of one command word and update the state
	function automatic draw_result_t run_command(input logic [2:0] kind, input logic [7:0] g);
		draw_result_t r;
		logic [63:0] acc;
		logic [30:0] s;
		r.value = '0;
		r.status = 1'b0;
		if (kind == KIND_SEED) begin
			seed_bank();
		end else if (kind <= KIND_LAST) begin
			if (g > highest) begin
				r.status = 1'b1;
			end else if (kind == KIND_DRAW) begin
				acc = '0;
				for (int j = 0; j < 4; j++) begin
					s = mod_mul(MULTS[j][30:0], cur_seed[j][g], j);
					cur_seed[j][g] = s;
					if (j % 2 == 1) acc = acc - {33'd0, s} * recip[j];
					else acc = acc + {33'd0, s} * recip[j];
				end
				r.value = acc[63:32];
			end else begin
				for (int j = 0; j < 4; j++) begin
					case (kind)
						KIND_REV: cur_seed[j][g] = mod_mul(inv_mult[j], cur_seed[j][g], j);
						KIND_INIT: begin
							last_seed[j][g] = init_seed[j][g];
							cur_seed[j][g] = last_seed[j][g];
						end
						KIND_SUB: begin
							last_seed[j][g] = mod_mul(sub_mult[j], last_seed[j][g], j);
							cur_seed[j][g] = last_seed[j][g];
						end
						default: cur_seed[j][g] = last_seed[j][g];
					endcase
				end
			end
		end
		return r;
	endfunction

	initial begin
		for (int j = 0; j < 4; j++) begin
			recip[j] = 64'hFFFF_FFFF_FFFF_FFFF / MODULI[j];
			inv_mult[j] = mod_pow(MULTS[j], MODULI[j] - 64'd2, j);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		draw_result_t want;
		if (!arst_n) begin
			seed_word[0] = 31'd11111111;
			seed_word[1] = 31'd22222222;
			seed_word[2] = 31'd33333333;
			seed_word[3] = 31'd44444444;
			gen_log = 7'd31;
			sub_log = 7'd41;
			highest = 8'd255;
			result_q.delete();
		end else begin
			// register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_SEED0: seed_word[0] = pwdata[30:0];
					REG_SEED1: seed_word[1] = pwdata[30:0];
					REG_SEED2: seed_word[2] = pwdata[30:0];
					REG_SEED3: seed_word[3] = pwdata[30:0];
					REG_GEN_LOG: gen_log = pwdata[6:0];
					REG_SUB_LOG: sub_log = pwdata[6:0];
					REG_HIGHEST: highest = pwdata[7:0];
					default: ;
				endcase
			end
			// result words against the oldest prediction
			if (m_tvalid && m_tready) begin
				if (result_q.size() == 0) begin
					$display("%0t: unexpected result word value=%h status=%b",
						$time, m_tdata, m_tuser);
					fails++;
				end else begin
					want = result_q.pop_front();
					if (m_tdata !== want.value) begin
						$display("%0t: uniform_value expected %h actual %h",
							$time, want.value, m_tdata);
						fails++;
					end
					if (m_tuser !== want.status) begin
						$display("%0t: status expected %b actual %b",
							$time, want.status, m_tuser);
						fails++;
					end
				end
			end
			// command words
			if (s_tvalid && s_tready)
				result_q.push_back(run_command(s_tuser, s_tdata));
		end
		pending = result_q.size();
	end

endmodule

[dv/reversible_clcg4_generator_bank_top_tb.sv]
// Testbench top for the generator bank: stimulus, stalls, config phases and verdict
module reversible_clcg4_generator_bank_top_tb import rcg_pkg::*;;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int ITEMS_PER_PHASE = 240;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] generator
	logic [2:0]  s_tuser;   // [2:0] kind
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [31:0] uniform_value
	logic        m_tuser;   // [0] status
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          fails;
	int          pending;
	int          cycles;
	int          burst_left;
	bit          hold_req;
	logic [7:0]  top_gen;

	reversible_clcg4_generator_bank_top uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	reversible_clcg4_generator_bank_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready), .fails(fails), .pending(pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver: stall pattern that changes at random, plus one long hold-off
	initial begin
		int mode;
		int run;
		bit held;
		m_tready = 1'b0;
		mode = 0;
		run = 0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req && !held) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
			end else begin
				if (run == 0) begin
					mode = $urandom_range(0, 3);
					run = $urandom_range(50, 300);
				end
				run--;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= $urandom_range(0, 1);
					2: m_tready <= ($urandom_range(0, 9) != 0);
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	// one command word, sent in bursts with random gaps
	task automatic send_word(input logic [2:0] kind, input logic [7:0] gen);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= gen;
		do @(posedge clk); while (!s_tready);
		burst_left--;
	endtask

	// stop sending and wait until every result word has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all(input logic [30:0] s0, input logic [30:0] s1,
		input logic [30:0] s2, input logic [30:0] s3, input logic [6:0] glog,
		input logic [6:0] slog, input logic [7:0] hi);
		reg_write(REG_SEED0, {1'b0, s0});
		reg_write(REG_SEED1, {1'b0, s1});
		reg_write(REG_SEED2, {1'b0, s2});
		reg_write(REG_SEED3, {1'b0, s3});
		reg_write(REG_GEN_LOG, {25'd0, glog});
		reg_write(REG_SUB_LOG, {25'd0, slog});
		reg_write(REG_HIGHEST, {24'd0, hi});
		top_gen = hi;
	endtask

	// random command; seeding is rare since it walks the bank up to the highest generator
	task automatic send_random();
		int r;
		logic [7:0] g;
		r = $urandom_range(0, 99);
		g = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, top_gen));
		if (r < 45) send_word(KIND_DRAW, g);
		else if (r < 60) send_word(KIND_REV, g);
		else if (r < 70) send_word(KIND_INIT, g);
		else if (r < 82) send_word(KIND_SUB, g);
		else if (r < 92) send_word(KIND_LAST, g);
		else if (r < 98) send_word(3'($urandom_range(6, 7)), g);
		else if (r < 99) send_word(KIND_DRAW, g);
		else send_word(KIND_SEED, 8'($urandom_range(0, 255)));
	endtask

	initial begin
		logic [30:0] sw [4];
		burst_left = 0;
		hold_req = 1'b0;
		top_gen = 8'd255;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, every command, edges of the generator field
		send_word(KIND_SEED, 8'hA5);
		send_word(KIND_DRAW, 8'd0);
		send_word(KIND_DRAW, 8'd255);
		send_word(KIND_REV, 8'd255);
		send_word(KIND_DRAW, 8'd255);
		send_word(KIND_SUB, 8'd0);
		send_word(KIND_DRAW, 8'd0);
		send_word(KIND_LAST, 8'd0);
		send_word(KIND_INIT, 8'd0);
		send_word(KIND_DRAW, 8'd0);
		send_word(3'd6, 8'd1);
		send_word(3'd7, 8'd255);
		drain();
		// out-of-range generators with a smaller bank
		reg_write(REG_HIGHEST, 32'd100);
		top_gen = 8'd100;
		send_word(KIND_SEED, 8'd0);
		send_word(KIND_DRAW, 8'd101);
		send_word(KIND_REV, 8'd255);
		send_word(KIND_SUB, 8'd200);
		send_word(KIND_DRAW, 8'd100);
		drain();

		// phases over several settings, extremes first
		for (int p = 0; p < 7; p++) begin
			case (p)
				0: write_all(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
					7'd127, 7'd127, 8'd255);
				1: write_all(31'd1, 31'd1, 31'd1, 31'd1, 7'd0, 7'd0, 8'd0);
				2: write_all(31'd2147483646, 31'd2147483542, 31'd2147483422, 31'd2147483322,
					7'd0, 7'd127, 8'd3);
				default: begin
					for (int j = 0; j < 4; j++) sw[j] = 31'($urandom);
					write_all(sw[0], sw[1], sw[2], sw[3], 7'($urandom_range(0, 127)),
						7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
				end
			endcase
			send_word(KIND_SEED, 8'($urandom_range(0, 255)));
			if (p == 3) hold_req = 1'b1;
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				send_random();
				if (p == 4 && i == ITEMS_PER_PHASE / 2) drain();
			end
			drain();
		end

		drain();
		if (fails == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

endmodule

[reversible_clcg4_generator_bank_top.f]
+incdir+rtl
rtl/rcg_pkg.sv
rtl/rcg_ram.sv
rtl/rcg_regs.sv
rtl/rcg_front.sv
rtl/rcg_queue.sv
rtl/rcg_mulmod.sv
rtl/rcg_frac.sv
rtl/rcg_back.sv
rtl/reversible_clcg4_generator_bank_top.sv
dv/reversible_clcg4_generator_bank_checker.sv
dv/reversible_clcg4_generator_bank_top_tb.sv
